// ===== rtl/core/fckd_pkg.sv =====
// Front-coded key decoder package: sizes, event and error codes, and the
// structs passed between the step logic and the top level. No dependencies.
`default_nettype none

package fckd_pkg;

  localparam int unsigned KEY_BUFFER_SIZE = 256;
  localparam int unsigned LenW = $clog2(KEY_BUFFER_SIZE);
  localparam int unsigned MaxPrefixCode = 31;

  typedef logic [LenW-1:0] len_t;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_ESCAPE,
    MODE_BODY,
    MODE_ENDED,
    MODE_ERROR
  } mode_e;

  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_PREFIX = 3'd1,
    EV_KEY    = 3'd2,
    EV_END    = 3'd3,
    EV_ERROR  = 3'd4,
    EV_ESCAPE = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_ESCAPE = 3'd1,
    ERR_PREFIX     = 3'd2,
    ERR_TOO_LONG   = 3'd3,
    ERR_TRUNCATED  = 3'd4
  } err_e;

  typedef struct packed {
    mode_e mode;
    err_e  err;
    len_t  cur_len;
    len_t  prev_len;
  } state_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] position;
    logic [7:0] character;
    logic [7:0] key_length;
    err_e       error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/front_coded_key_decoder.sv =====
// Front-coded key decoder top level: input register, step logic, decoder
// state and result register. Depends on fckd_pkg and fckd_step.
//
// Usage:
//   Slave stream s_axis_*: one key-stream byte per request in tdata[7:0];
//   tlast marks end of stream (the byte is then ignored).
//   Master stream m_axis_*: one result per input request. tuser carries
//   the event code, tdata the position, character, key length and error
//   code. The consumer rebuilds each key from character and prefix events.
//   Path: a request accepted into the input register is decoded by the step
//   logic into the result register, from which m_axis presents it.
//   Throughput: one request per cycle while m_axis_tready is high, set by
//   the decoder state update between the input and result registers.
//   Reset: both stages empty, decoder at key start, previous key empty.
//   Stall: with m_axis_tready low the result holds; one more request is
//   taken into the input register, then s_axis_tready drops until the
//   result is taken. Stream end and errors stay sticky until reset.
`default_nettype none

module front_coded_key_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] position, [15:8] character,
                                     // [23:16] key_length, [26:24] error_code
  output logic [2:0]  m_axis_tuser   // [2:0] event_res
);
  import fckd_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       out_valid_q;
  res_t       res_q;
  res_t       res_d;
  state_t     state_q;
  state_t     state_d;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  fckd_step u_step (
    .state_i (state_q),
    .byte_i  (byte_q),
    .eos_i   (eos_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_START, err: ERR_NONE, cur_len: '0, prev_len: '0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q <= s_axis_tdata;
      eos_q  <= s_axis_tlast;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.ev;
  assign m_axis_tdata  = {5'd0, res_q.error_code, res_q.key_length,
                          res_q.character, res_q.position};

endmodule

`default_nettype wire

// ===== rtl/core/fckd_step.sv =====
// Front-coded key decoder step: next decoder state and the result for one
// request. Pure combinational logic. Depends on fckd_pkg.
`default_nettype none

module fckd_step (
  input  fckd_pkg::state_t state_i,
  input  logic [7:0]       byte_i,
  input  logic             eos_i,
  output fckd_pkg::state_t state_o,
  output fckd_pkg::res_t   res_o
);
  import fckd_pkg::*;

  len_t b_len;
  logic b_zero;
  logic b_small;

  assign b_len   = len_t'(byte_i);
  assign b_zero  = (byte_i == 8'd0);
  assign b_small = (byte_i <= 8'(MaxPrefixCode));

  always_comb begin
    state_o = state_i;
    res_o   = '{ev: EV_CHAR, position: 8'd0, character: 8'd0, key_length: 8'd0,
                error_code: ERR_NONE};
    unique case (state_i.mode)
      MODE_START: begin
        if (eos_i || b_zero) begin
          state_o.mode = MODE_ENDED;
          res_o.ev     = EV_END;
        end else if (byte_i == 8'd1) begin
          state_o.mode = MODE_ESCAPE;
          res_o.ev     = EV_ESCAPE;
        end else if (b_small) begin
          if (b_len > state_i.prev_len) begin
            state_o.mode     = MODE_ERROR;
            state_o.err      = ERR_PREFIX;
            res_o.ev         = EV_ERROR;
            res_o.error_code = ERR_PREFIX;
          end else begin
            state_o.mode     = MODE_BODY;
            state_o.cur_len  = b_len;
            res_o.ev         = EV_PREFIX;
            res_o.key_length = byte_i;
          end
        end else begin
          state_o.mode    = MODE_BODY;
          state_o.cur_len = len_t'(1);
          res_o.ev        = EV_CHAR;
          res_o.character = byte_i;
        end
      end
      MODE_ESCAPE: begin
        if (eos_i || b_small) begin
          state_o.mode     = MODE_ERROR;
          state_o.err      = ERR_BAD_ESCAPE;
          res_o.ev         = EV_ERROR;
          res_o.error_code = ERR_BAD_ESCAPE;
        end else if (b_len > state_i.prev_len) begin
          state_o.mode     = MODE_ERROR;
          state_o.err      = ERR_PREFIX;
          res_o.ev         = EV_ERROR;
          res_o.error_code = ERR_PREFIX;
        end else begin
          state_o.mode     = MODE_BODY;
          state_o.cur_len  = b_len;
          res_o.ev         = EV_PREFIX;
          res_o.key_length = byte_i;
        end
      end
      MODE_BODY: begin
        if (eos_i) begin
          state_o.mode     = MODE_ERROR;
          state_o.err      = ERR_TRUNCATED;
          res_o.ev         = EV_ERROR;
          res_o.error_code = ERR_TRUNCATED;
        end else if (b_zero) begin
          state_o.mode     = MODE_START;
          state_o.prev_len = state_i.cur_len;
          res_o.ev         = EV_KEY;
          res_o.key_length = state_i.cur_len[7:0];
        end else if (state_i.cur_len >= len_t'(KEY_BUFFER_SIZE - 1)) begin
          state_o.mode     = MODE_ERROR;
          state_o.err      = ERR_TOO_LONG;
          res_o.ev         = EV_ERROR;
          res_o.error_code = ERR_TOO_LONG;
        end else begin
          state_o.cur_len = state_i.cur_len + len_t'(1);
          res_o.ev        = EV_CHAR;
          res_o.position  = state_i.cur_len[7:0];
          res_o.character = byte_i;
        end
      end
      MODE_ENDED: begin
        res_o.ev = EV_END;
      end
      MODE_ERROR: begin
        res_o.ev         = EV_ERROR;
        res_o.error_code = state_i.err;
      end
      default: begin
        res_o.ev = EV_END;
      end
    endcase
  end

endmodule

`default_nettype wire
